FILE: rtl/ascii_motor_command_decoder_core_assert.svh
// Assertion helpers shared by the checker files of the command decoder.
// Each macro builds one labeled concurrent assertion on the rising edge of
// clk_i, disabled while rst_ni is low.
`ifndef ASCII_MOTOR_COMMAND_DECODER_CORE_ASSERT_SVH
`define ASCII_MOTOR_COMMAND_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMCD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AMCD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/amcd_pkg.sv
`timescale 1ns / 1ps

package amcd_pkg;

  // Byte codes used by the line parser.
  localparam logic [7:0] ASCII_LF    = 8'd10;
  localparam logic [7:0] ASCII_SPACE = 8'd32;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_COMMA = 8'h2C;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;

  // Keyword table: DRIVE, BOOM, DIPPER, BUCKET, BASE and the all-stop keyword.
  localparam int KW_NUM    = 6;
  localparam int KW_DRIVE  = 0;
  localparam int KW_BOOM   = 1;
  localparam int KW_DIPPER = 2;
  localparam int KW_BUCKET = 3;
  localparam int KW_BASE   = 4;
  localparam int KW_STOP   = 5;

  localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
    '{"D", "R", "I", "V", "E", ",", 8'h00, 8'h00},
    '{"B", "O", "O", "M", ",", 8'h00, 8'h00, 8'h00},
    '{"D", "I", "P", "P", "E", "R", ",", 8'h00},
    '{"B", "U", "C", "K", "E", "T", ",", 8'h00},
    '{"B", "A", "S", "E", ",", 8'h00, 8'h00, 8'h00},
    '{"S", "T", "O", "P", "_", "A", "L", "L"}
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{4'd6, 4'd5, 4'd7, 4'd7, 4'd5, 4'd8};

  // Result targets.
  localparam logic [2:0] TGT_BOOM   = 3'd4;
  localparam logic [2:0] TGT_DIPPER = 3'd5;
  localparam logic [2:0] TGT_BUCKET = 3'd6;
  localparam logic [2:0] TGT_SERVO  = 3'd7;

  // Register reset values.
  localparam logic [6:0] INVERT_MASK_RST = 7'd12;
  localparam logic [7:0] SERVO_MIN_RST   = 8'd20;
  localparam logic [7:0] SERVO_MAX_RST   = 8'd160;
  localparam logic [7:0] SERVO_STEP_RST  = 8'd3;
  localparam logic [7:0] SERVO_POS_RST   = 8'd90;

  // Command queue between the parser and the result sequencer.
  localparam int AMCD_QDEPTH = 4;
  localparam int AMCD_QPTR_W = $clog2(AMCD_QDEPTH);

  typedef enum logic [1:0] {
    CMD_DRIVE = 2'd0,
    CMD_ACT   = 2'd1,
    CMD_BASE  = 2'd2,
    CMD_STOP  = 2'd3
  } amcd_cmd_kind_e;

  // One decoded command line.
  typedef struct packed {
    amcd_cmd_kind_e kind;
    logic [2:0]     target;
    logic [7:0]     mag_a;
    logic           neg_a;
    logic [7:0]     mag_b;
    logic           neg_b;
  } amcd_cmd_t;

  typedef struct packed {
    logic [6:0] invert_mask;
    logic [7:0] servo_min;
    logic [7:0] servo_max;
    logic [7:0] servo_step;
  } amcd_cfg_t;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == ASCII_SPACE) || ((ch >= 8'd9) && (ch <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= ASCII_ZERO) && (ch <= ASCII_NINE);
  endfunction

  // Append one decimal digit, saturating the magnitude at 511.
  function automatic logic [8:0] mag_next(input logic [8:0] m, input logic [7:0] ch);
    logic [12:0] v;
    v = 13'({m, 3'b000}) + 13'({m, 1'b0}) + 13'(ch[3:0]);
    return (v > 13'd511) ? 9'd511 : v[8:0];
  endfunction

  // Speed magnitudes are clamped to 255.
  function automatic logic [7:0] mag_clamp(input logic [8:0] m);
    return m[8] ? 8'hFF : m[7:0];
  endfunction

endpackage

FILE: rtl/amcd_front.sv
`timescale 1ns / 1ps

module amcd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          rx_byte_i,
  output logic                push_o,
  output amcd_pkg::amcd_cmd_t cmd_o
);
  import amcd_pkg::*;

  typedef enum logic [5:0] {
    PH_LEAD = 6'b000001,
    PH_KEY  = 6'b000010,
    PH_NUM  = 6'b000100,
    PH_SKIP = 6'b001000,
    PH_TAIL = 6'b010000,
    PH_DEAD = 6'b100000
  } amcd_phase_e;

  amcd_phase_e phase_q, phase_d;
  logic [3:0]  kw_pos_q, kw_pos_d;
  logic [5:0]  alive_q, alive_d;
  logic [8:0]  mag1_q, mag1_d, mag2_q, mag2_d;
  logic        neg1_q, neg1_d, neg2_q, neg2_d;
  logic        second_q, second_d, sign_q, sign_d, digit_q, digit_d;

  logic [3:0]  kw_pos_inc;
  logic [5:0]  alive_new, key_done_oh, key_alive;
  logic        key_done;
  amcd_phase_e key_phase;
  logic        ch_ws, ch_digit, started;

  assign kw_pos_inc = kw_pos_q + 4'd1;
  assign ch_ws      = is_ws(rx_byte_i);
  assign ch_digit   = is_digit(rx_byte_i);
  assign started    = sign_q | digit_q;

  // Keyword match for the current byte: narrow the candidates, then look
  // for one that has just been completed.
  always_comb begin
    alive_new   = '0;
    key_done    = 1'b0;
    key_done_oh = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      alive_new[k] = alive_q[k] && (kw_pos_q < KW_LEN[k]) &&
                     (KW_TEXT[k][kw_pos_q[2:0]] == rx_byte_i);
    end
    for (int k = 0; k < KW_NUM; k++) begin
      if (!key_done && alive_new[k] && (KW_LEN[k] == kw_pos_inc)) begin
        key_done       = 1'b1;
        key_done_oh[k] = 1'b1;
      end
    end
    if (alive_new == '0) begin
      key_phase = PH_DEAD;
      key_alive = '0;
    end else if (key_done) begin
      key_alive = key_done_oh;
      key_phase = key_done_oh[KW_STOP] ? PH_TAIL : PH_NUM;
    end else begin
      key_alive = alive_new;
      key_phase = PH_KEY;
    end
  end

  // Command record built when a newline closes the line.
  always_comb begin
    cmd_o.kind   = CMD_ACT;
    cmd_o.target = TGT_BOOM;
    cmd_o.mag_a  = mag_clamp(mag1_q);
    cmd_o.neg_a  = neg1_q;
    cmd_o.mag_b  = mag_clamp(mag2_q);
    cmd_o.neg_b  = neg2_q;
    push_o       = 1'b0;
    if (fire_i && (rx_byte_i == ASCII_LF)) begin
      if (phase_q == PH_TAIL) begin
        cmd_o.kind = CMD_STOP;
        push_o     = 1'b1;
      end else if ((phase_q == PH_NUM) || (phase_q == PH_SKIP)) begin
        push_o = 1'b1;
        if (alive_q[KW_DRIVE]) begin
          cmd_o.kind = CMD_DRIVE;
          push_o     = second_q;
        end else if (alive_q[KW_BASE]) begin
          cmd_o.kind = CMD_BASE;
        end else if (alive_q[KW_DIPPER]) begin
          cmd_o.target = TGT_DIPPER;
        end else if (alive_q[KW_BUCKET]) begin
          cmd_o.target = TGT_BUCKET;
        end
      end
    end
  end

  // Per-byte parse state update.
  always_comb begin
    phase_d  = phase_q;
    kw_pos_d = kw_pos_q;
    alive_d  = alive_q;
    mag1_d   = mag1_q;
    mag2_d   = mag2_q;
    neg1_d   = neg1_q;
    neg2_d   = neg2_q;
    second_d = second_q;
    sign_d   = sign_q;
    digit_d  = digit_q;
    if (fire_i) begin
      if (rx_byte_i == ASCII_LF) begin
        phase_d  = PH_LEAD;
        kw_pos_d = '0;
        alive_d  = '1;
        mag1_d   = '0;
        mag2_d   = '0;
        neg1_d   = 1'b0;
        neg2_d   = 1'b0;
        second_d = 1'b0;
        sign_d   = 1'b0;
        digit_d  = 1'b0;
      end else begin
        unique case (phase_q)
          PH_LEAD: begin
            if (!ch_ws) begin
              phase_d  = key_phase;
              alive_d  = key_alive;
              kw_pos_d = kw_pos_inc;
            end
          end
          PH_KEY: begin
            phase_d  = key_phase;
            alive_d  = key_alive;
            kw_pos_d = kw_pos_inc;
          end
          PH_NUM: begin
            if (!started && ch_ws) begin
              phase_d = PH_NUM;
            end else if (!started &&
                         ((rx_byte_i == ASCII_PLUS) || (rx_byte_i == ASCII_MINUS))) begin
              sign_d = 1'b1;
              if (rx_byte_i == ASCII_MINUS) begin
                if (second_q) begin
                  neg2_d = 1'b1;
                end else begin
                  neg1_d = 1'b1;
                end
              end
            end else if (ch_digit) begin
              digit_d = 1'b1;
              if (second_q) begin
                mag2_d = mag_next(mag2_q, rx_byte_i);
              end else begin
                mag1_d = mag_next(mag1_q, rx_byte_i);
              end
            end else if (alive_q[KW_DRIVE] && !second_q && (rx_byte_i == ASCII_COMMA)) begin
              second_d = 1'b1;
              sign_d   = 1'b0;
              digit_d  = 1'b0;
            end else begin
              phase_d = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (alive_q[KW_DRIVE] && !second_q && (rx_byte_i == ASCII_COMMA)) begin
              second_d = 1'b1;
              sign_d   = 1'b0;
              digit_d  = 1'b0;
              phase_d  = PH_NUM;
            end
          end
          PH_TAIL: begin
            if (!ch_ws) begin
              phase_d = PH_DEAD;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      kw_pos_q <= '0;
      alive_q  <= '1;
      mag1_q   <= '0;
      mag2_q   <= '0;
      neg1_q   <= 1'b0;
      neg2_q   <= 1'b0;
      second_q <= 1'b0;
      sign_q   <= 1'b0;
      digit_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      kw_pos_q <= kw_pos_d;
      alive_q  <= alive_d;
      mag1_q   <= mag1_d;
      mag2_q   <= mag2_d;
      neg1_q   <= neg1_d;
      neg2_q   <= neg2_d;
      second_q <= second_d;
      sign_q   <= sign_d;
      digit_q  <= digit_d;
    end
  end

endmodule

FILE: rtl/amcd_queue.sv
`timescale 1ns / 1ps

module amcd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  amcd_pkg::amcd_cmd_t cmd_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output amcd_pkg::amcd_cmd_t head_o
);
  import amcd_pkg::*;

  amcd_cmd_t              entry_q [AMCD_QDEPTH];
  logic [AMCD_QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AMCD_QPTR_W:0]   count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == (AMCD_QPTR_W + 1)'(AMCD_QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/amcd_back.sv
`timescale 1ns / 1ps

module amcd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  amcd_pkg::amcd_cfg_t cfg_i,
  input  logic                head_valid_i,
  input  amcd_pkg::amcd_cmd_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          target_o,
  output logic                drive_fwd_o,
  output logic                drive_rev_o,
  output logic [7:0]          duty_o,
  output logic [7:0]          servo_angle_o,
  output logic                last_o
);
  import amcd_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic [2:0] target_q, r_target;
  logic       fwd_q, rev_q, r_fwd, r_rev;
  logic [7:0] duty_q, angle_q, r_duty, r_angle;
  logic       last_q, r_last;
  logic [2:0] idx_q, idx_d;
  logic [7:0] servo_q, servo_d, servo_next;
  logic       load;
  logic [7:0] r_mag;
  logic       r_neg, r_bridge, eff_neg;
  logic [7:0] inv_ext;
  logic signed [9:0] pos, step, lo, hi;

  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = load && r_last;
  assign inv_ext = {1'b0, cfg_i.invert_mask};

  // New servo angle: step by one increment on a unit value, then clamp.
  always_comb begin
    pos  = $signed({2'b00, servo_q});
    step = $signed({2'b00, cfg_i.servo_step});
    lo   = $signed({2'b00, cfg_i.servo_min});
    hi   = $signed({2'b00, cfg_i.servo_max});
    if (head_i.mag_a == 8'd1) begin
      pos = head_i.neg_a ? pos - step : pos + step;
    end
    if (pos < lo) begin
      servo_next = cfg_i.servo_min;
    end else if (pos > hi) begin
      servo_next = cfg_i.servo_max;
    end else begin
      servo_next = pos[7:0];
    end
  end

  // Result for the current step of the command at the queue head.
  always_comb begin
    r_target = idx_q;
    r_mag    = '0;
    r_neg    = 1'b0;
    r_bridge = 1'b1;
    r_last   = 1'b0;
    r_angle  = '0;
    unique case (head_i.kind)
      CMD_DRIVE: begin
        r_mag  = idx_q[1] ? head_i.mag_b : head_i.mag_a;
        r_neg  = idx_q[1] ? head_i.neg_b : head_i.neg_a;
        r_last = (idx_q == 3'd3);
      end
      CMD_ACT: begin
        r_target = head_i.target;
        r_mag    = head_i.mag_a;
        r_neg    = head_i.neg_a;
        r_last   = 1'b1;
      end
      CMD_BASE: begin
        r_target = TGT_SERVO;
        r_bridge = 1'b0;
        r_last   = 1'b1;
        r_angle  = servo_next;
      end
      CMD_STOP: begin
        r_last = (idx_q == 3'd6);
      end
      default: begin
        r_last = 1'b1;
      end
    endcase
    eff_neg = r_neg ^ inv_ext[r_target];
    r_fwd   = r_bridge && (r_mag != '0) && !eff_neg;
    r_rev   = r_bridge && (r_mag != '0) && eff_neg;
    r_duty  = r_bridge ? r_mag : '0;
  end

  // Step counter and servo position.
  always_comb begin
    idx_d   = idx_q;
    servo_d = servo_q;
    if (load) begin
      idx_d = r_last ? '0 : idx_q + 3'd1;
      if (head_i.kind == CMD_BASE) begin
        servo_d = servo_next;
      end
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      servo_q     <= SERVO_POS_RST;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      servo_q     <= servo_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      target_q <= r_target;
      fwd_q    <= r_fwd;
      rev_q    <= r_rev;
      duty_q   <= r_duty;
      angle_q  <= r_angle;
      last_q   <= r_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_o      = target_q;
  assign drive_fwd_o   = fwd_q;
  assign drive_rev_o   = rev_q;
  assign duty_o        = duty_q;
  assign servo_angle_o = angle_q;
  assign last_o        = last_q;

endmodule

FILE: rtl/ascii_motor_command_decoder_core.sv
`timescale 1ns / 1ps

// Serial command-line decoder for seven motor bridges and one base servo.
// Input channel: one received byte per transaction (rx_byte_i, in_valid_i,
// in_stall_o). A newline closes a line; recognized lines yield results.
// Output channel: one bridge or servo setting per transaction (target_o,
// drive_fwd_o, drive_rev_o, duty_o, servo_angle_o, last_o), with last_o set
// on the final result of a line. DRIVE gives four results, the all-stop line
// seven, BOOM, DIPPER, BUCKET and BASE one each.
// Throughput: one byte per cycle on the input while the queue has room, one
// result per cycle on the output while out_stall_i is low. The parser takes
// each byte as it comes; a four-entry line queue feeds the result sequencer.
// A decoded line passes the queue and then the output register before its
// first result. in_stall_o rises only while the line queue is full.
// When the receiver holds out_stall_i, the current result stays on the port
// and the sequencer waits; the parser keeps taking bytes until the queue
// fills. Reset empties the queue, clears the parser to line start, sets the
// servo position to 90 and loads the register defaults. Registers are set
// over the APB port at byte addresses 0, 4, 8 and 12.
module ascii_motor_command_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // Result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  target_o,
  output logic        drive_fwd_o,
  output logic        drive_rev_o,
  output logic [7:0]  duty_o,
  output logic [7:0]  servo_angle_o,
  output logic        last_o,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import amcd_pkg::*;

  typedef enum logic [1:0] {
    REG_INVERT_MASK = 2'd0,
    REG_SERVO_MIN   = 2'd1,
    REG_SERVO_MAX   = 2'd2,
    REG_SERVO_STEP  = 2'd3
  } amcd_reg_e;

  amcd_cfg_t cfg_q, cfg_d;
  amcd_reg_e reg_sel;
  logic      cfg_wr;

  amcd_cmd_t front_cmd, head_cmd;
  logic      front_push, q_full, q_valid, q_pop, in_fire;

  assign pready  = 1'b1;
  assign reg_sel = amcd_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_INVERT_MASK: cfg_d.invert_mask = pwdata[6:0];
        REG_SERVO_MIN:   cfg_d.servo_min   = pwdata[7:0];
        REG_SERVO_MAX:   cfg_d.servo_max   = pwdata[7:0];
        REG_SERVO_STEP:  cfg_d.servo_step  = pwdata[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_sel)
      REG_INVERT_MASK: prdata = 32'(cfg_q.invert_mask);
      REG_SERVO_MIN:   prdata = 32'(cfg_q.servo_min);
      REG_SERVO_MAX:   prdata = 32'(cfg_q.servo_max);
      REG_SERVO_STEP:  prdata = 32'(cfg_q.servo_step);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invert_mask <= INVERT_MASK_RST;
      cfg_q.servo_min   <= SERVO_MIN_RST;
      cfg_q.servo_max   <= SERVO_MAX_RST;
      cfg_q.servo_step  <= SERVO_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Bytes are taken whenever the line queue has room.
  assign in_stall_o = q_full;
  assign in_fire    = in_valid_i && !q_full;

  amcd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .rx_byte_i (rx_byte_i),
    .push_o    (front_push),
    .cmd_o     (front_cmd)
  );

  amcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head_cmd)
  );

  amcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (q_valid),
    .head_i        (head_cmd),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .target_o      (target_o),
    .drive_fwd_o   (drive_fwd_o),
    .drive_rev_o   (drive_rev_o),
    .duty_o        (duty_o),
    .servo_angle_o (servo_angle_o),
    .last_o        (last_o)
  );

endmodule

FILE: rtl/amcd_checker.sv
`timescale 1ns / 1ps

`include "ascii_motor_command_decoder_core_assert.svh"

module amcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] target_o,
  input logic       drive_fwd_o,
  input logic       drive_rev_o,
  input logic [7:0] duty_o,
  input logic [7:0] servo_angle_o,
  input logic       last_o
);
  import amcd_pkg::*;

  // A stalled result stays on the port unchanged.
  `AMCD_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(target_o) && $stable(duty_o) && $stable(last_o), "stalled result changed")

  // A servo result is always the only result of its line and drives no bridge.
  `AMCD_ASSERT_IMP(a_servo_shape, out_valid_o && (target_o == TGT_SERVO), last_o && !drive_fwd_o && !drive_rev_o && (duty_o == 8'd0), "malformed servo result")

  // A bridge result has consistent direction bits and duty and no angle.
  `AMCD_ASSERT_IMP(a_bridge_shape, out_valid_o && (target_o != TGT_SERVO), (servo_angle_o == 8'd0) && !(drive_fwd_o && drive_rev_o) && ((duty_o == 8'd0) == (!drive_fwd_o && !drive_rev_o)), "malformed bridge result")

  // Within a multi-result line the next result follows at once on the next target.
  `AMCD_ASSERT_NXT(a_run_order, out_valid_o && !out_stall_i && !last_o, out_valid_o && (target_o == $past(target_o) + 3'd1), "broken result run")

endmodule

bind ascii_motor_command_decoder_core amcd_checker u_amcd_checker (.*);
